// ===== src/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// Flight countdown timer package
// Shared word types, command and status structs, and constants.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int unsigned StampW      = 16;
    localparam int unsigned SecondsW    = 15;
    localparam int unsigned PhaseW      = 6;
    localparam int unsigned CfgIndexW   = 2;
    localparam int unsigned CfgDataW    = 16;

    localparam logic [StampW-1:0]   MsPerSecond      = 16'd1000;
    localparam logic [StampW-1:0]   TwoSeconds       = 16'd2000;
    localparam logic [StampW-1:0]   MaxDeltaMs       = 16'd64000;
    localparam logic [PhaseW-1:0]   LastMinutePhase  = 6'd59;
    localparam logic [SecondsW-1:0] WarnWindow       = 15'd10;
    localparam logic [SecondsW-1:0] ElapsedMax       = 15'd32767;
    localparam logic [SecondsW-1:0] TargetReset      = 15'd1;
    localparam logic                CountUpReset     = 1'b1;

    localparam logic OpTick  = 1'b0;
    localparam logic OpReset = 1'b1;

    localparam logic [CfgIndexW-1:0] CfgTarget  = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgCountUp = 2'd1;

    typedef enum logic [1:0] {
        ALERT_NONE   = 2'd0,
        ALERT_TARGET = 2'd1,
        ALERT_WARN   = 2'd2,
        ALERT_MINUTE = 2'd3
    } alert_t;

    typedef struct packed {
        logic              opcode;
        logic              active;
        logic [StampW-1:0] now_ms;
    } tick_word_t;

    typedef struct packed {
        logic signed [15:0] shown_time;
        logic               second_done;
        alert_t             alert;
        logic               last_result;
    } sec_word_t;

    typedef struct packed {
        logic load_reset;
        logic load_tick;
        logic step;
    } fct_cmd_t;

    typedef struct packed {
        logic is_reset_op;
        logic tick_live;
        logic total_ge_sec;
        logic total_lt_two_sec;
    } fct_stat_t;

endpackage

// ===== src/fct_ctrl.sv =====
// ----------------------------------------------------------------------------
// Flight countdown timer controller
// Accepts tick words and issues one datapath step per emitted second.
// ----------------------------------------------------------------------------
module fct_ctrl
    import fct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tick_valid,
    output logic      tick_ready,
    output logic      sec_valid,
    input  logic      sec_ready,
    input  fct_stat_t stat,
    output fct_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   sec_valid_reg, sec_valid_next;
    logic   slot_free;

    assign tick_ready = (state_reg == ST_IDLE);
    assign sec_valid  = sec_valid_reg;
    assign slot_free  = !sec_valid_reg || sec_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    if (stat.is_reset_op)
                    begin
                        cmd.load_reset = 1'b1;
                    end
                    else if (stat.tick_live)
                    begin
                        cmd.load_tick = 1'b1;
                        state_next    = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (!stat.total_ge_sec)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.total_lt_two_sec)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.step)
        begin
            sec_valid_next = 1'b1;
        end
        else if (sec_ready)
        begin
            sec_valid_next = 1'b0;
        end
        else
        begin
            sec_valid_next = sec_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

endmodule

// ===== src/fct_datapath.sv =====
// ----------------------------------------------------------------------------
// Flight countdown timer datapath
// Holds the configuration, stamp, millisecond total, seconds count, minute phase and the output word.
// ----------------------------------------------------------------------------
module fct_datapath
    import fct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tick_word_t           tick_word,
    input  logic                 cfg_write,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    input  fct_cmd_t             cmd,
    output fct_stat_t            stat,
    output sec_word_t            sec_word
);

    logic [SecondsW-1:0] target_reg;
    logic                count_up_reg;
    logic [SecondsW-1:0] elapsed_reg, elapsed_next;
    logic [PhaseW-1:0]   phase_reg, phase_next;
    logic [StampW-1:0]   stamp_reg;
    logic [StampW-1:0]   total_reg;
    sec_word_t           word_reg, word_next;

    logic [StampW-1:0]   delta_raw;
    logic [StampW-1:0]   delta;
    logic                saturated;
    logic [SecondsW-1:0] to_target;
    logic [15:0]         remaining;

    assign delta_raw = tick_word.now_ms - stamp_reg;
    assign delta     = (delta_raw > MaxDeltaMs) ? MaxDeltaMs : delta_raw;

    assign stat.is_reset_op      = (tick_word.opcode == OpReset);
    assign stat.tick_live        = tick_word.active && (tick_word.now_ms != stamp_reg);
    assign stat.total_ge_sec     = (total_reg >= MsPerSecond);
    assign stat.total_lt_two_sec = (total_reg < TwoSeconds);

    assign saturated = (elapsed_reg == ElapsedMax);

    always_comb
    begin
        if (saturated)
        begin
            elapsed_next = elapsed_reg;
            phase_next   = phase_reg;
        end
        else
        begin
            elapsed_next = elapsed_reg + 15'd1;
            phase_next   = (phase_reg == LastMinutePhase) ? '0 : phase_reg + 6'd1;
        end
        to_target = target_reg - elapsed_next;
        remaining = {1'b0, target_reg} - {1'b0, elapsed_next};

        word_next.shown_time  = count_up_reg ? $signed({1'b0, elapsed_next})
                                             : $signed(remaining);
        word_next.second_done = 1'b1;
        word_next.last_result = (total_reg < TwoSeconds);
        if (saturated)
        begin
            word_next.alert = ALERT_NONE;
        end
        else if (elapsed_next == target_reg)
        begin
            word_next.alert = ALERT_TARGET;
        end
        else if ((elapsed_next < target_reg) && (to_target <= WarnWindow))
        begin
            word_next.alert = ALERT_WARN;
        end
        else if (phase_next == '0)
        begin
            word_next.alert = ALERT_MINUTE;
        end
        else
        begin
            word_next.alert = ALERT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TargetReset;
            count_up_reg <= CountUpReset;
            elapsed_reg  <= '0;
            phase_reg    <= '0;
            stamp_reg    <= '0;
            total_reg    <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == CfgTarget))
            begin
                target_reg <= cfg_data[SecondsW-1:0];
            end
            if (cfg_write && (cfg_index == CfgCountUp))
            begin
                count_up_reg <= cfg_data[0];
            end
            if (cmd.load_reset)
            begin
                elapsed_reg <= '0;
                phase_reg   <= '0;
                total_reg   <= '0;
                stamp_reg   <= tick_word.now_ms;
            end
            else if (cmd.load_tick)
            begin
                stamp_reg <= tick_word.now_ms;
                total_reg <= total_reg + delta;
            end
            else if (cmd.step)
            begin
                elapsed_reg <= elapsed_next;
                phase_reg   <= phase_next;
                total_reg   <= total_reg - MsPerSecond;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            word_reg <= word_next;
        end
    end

    assign sec_word = word_reg;

endmodule

// ===== src/flight_countdown_timer.sv =====
// ----------------------------------------------------------------------------
// Flight countdown timer
// Counts flight seconds from a millisecond stamp and emits one word per second.
//
//   Channel | Handshake             | Word
//   --------+-----------------------+---------------------------------------
//   tick    | tick_valid/tick_ready | opcode, active, now_ms
//   sec     | sec_valid/sec_ready   | shown_time, second_done, alert, last
//   cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A live tick word is loaded first, then one second word is emitted per cycle
// (up to 64); a live tick that completes no second passes through the run state
// with no step before it returns to idle. A reset word or an idle tick is
// handled in the idle state alone. Output stalls hold the loop; the next tick
// word is taken while the final second word still waits.
// Reset is asynchronous and clears the counting state; config gets its defaults.
// ----------------------------------------------------------------------------
module flight_countdown_timer
    import fct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick_valid,
    output logic                 tick_ready,
    input  tick_word_t           tick_word,
    output logic                 sec_valid,
    input  logic                 sec_ready,
    output sec_word_t            sec_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    fct_cmd_t  cmd;
    fct_stat_t stat;

    assign cfg_ready = 1'b1;

    fct_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .sec_valid  (sec_valid),
        .sec_ready  (sec_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    fct_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_word (tick_word),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .sec_word  (sec_word)
    );

    // A second is only counted while at least one whole second is pending.
    a_step_needs_second: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> stat.total_ge_sec)
        else $error("step issued with less than one second pending");

    // Every step leaves a word on the output.
    a_step_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> sec_valid)
        else $error("step did not present a second word");

    // While idle the remainder is always below one second.
    a_idle_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        tick_ready |-> !stat.total_ge_sec)
        else $error("idle with a whole second still pending");

endmodule
